[rtl/assert_macros.svh]
// Assertion macros used by sensor_frame_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

[rtl/sfc_pkg.sv]
// Package for the sensor frame checker: constants, status codes, CRC and float helpers.
// No dependencies.
package sfc_pkg;
  localparam logic [4:0]  FrameLast = 5'd27;
  localparam logic [4:0]  CrcSpan   = 5'd24;
  localparam logic [31:0] CrcPoly   = 32'hedb88320;
  localparam logic [7:0]  Magic0    = 8'h46;
  localparam logic [7:0]  Magic1    = 8'h57;
  localparam logic [7:0]  Version   = 8'h01;
  localparam logic [7:0]  FrameLen  = 8'd28;
  localparam logic [31:0] Max32     = 32'hffffffff;
  localparam logic [47:0] Max48     = 48'hffffffffffff;
  localparam logic [63:0] MinThrRst = 64'hffefffffffffffff;
  localparam logic [63:0] MaxThrRst = 64'h7fefffffffffffff;

  typedef enum logic [2:0] {
    ST_VALID = 3'd0, ST_BAD_HDR = 3'd1, ST_BAD_PAY = 3'd2,
    ST_TRUNC = 3'd3, ST_END = 3'd4
  } status_t;

  typedef enum logic [0:0] { OP_DATA = 1'b0, OP_END = 1'b1 } opcode_t;
  typedef enum logic [0:0] { REG_MIN = 1'b0, REG_MAX = 1'b1 } reg_idx_t;

  // Captured frame presented to the accounting stage.
  typedef struct packed {
    logic        fin;      // byte 27 completed a frame
    logic        eos;      // end-of-stream item
    logic        partial;  // partial frame pending at end of stream
    logic        hdr_ok;
    logic        crc_ok;
    logic        pad_ok;
    logic [31:0] seq;
    logic [63:0] tstamp;
    logic [15:0] sensor;
    logic [31:0] value;
  } frame_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) r = (r >> 1) ^ (CrcPoly & {32{r[0]}});
    return r;
  endfunction

  function automatic logic [31:0] inc32(input logic [31:0] c);
    return (c == Max32) ? c : c + 32'd1;
  endfunction

  // Converts a float32 bit pattern to double bits (value is finite here).
  function automatic logic [63:0] f2d(input logic [31:0] f);
    logic [63:0] d;
    logic [22:0] m;
    logic [4:0]  lz;
    logic        found;
    m = f[22:0];
    lz = 5'd0;
    found = 1'b0;
    for (int i = 22; i >= 0; i--) begin
      if (!found && m[i]) begin
        found = 1'b1;
        lz = 5'(22 - i);
      end
    end
    if (f[30:23] == 8'd0) begin
      if (m == 23'd0) d = {f[31], 63'd0};
      else d = {f[31], 11'(11'd1023 - 11'd127 - {6'd0, lz}),
                (52'({m, 29'd0}) << (lz + 5'd1))};
    end else begin
      d = {f[31], 11'({3'd0, f[30:23]} + 11'd896), m, 29'd0};
    end
    return d;
  endfunction

  function automatic logic is_nan(input logic [63:0] d);
    return (d[62:52] == 11'h7ff) && (d[51:0] != 52'd0);
  endfunction

  // a < b for doubles; false with NaN.
  function automatic logic d_lt(input logic [63:0] a, input logic [63:0] b);
    logic r;
    if (is_nan(a) || is_nan(b)) r = 1'b0;
    else if (a[62:0] == 63'd0 && b[62:0] == 63'd0) r = 1'b0;
    else if (a[63] != b[63]) r = a[63];
    else if (!a[63]) r = a[62:0] < b[62:0];
    else r = a[62:0] > b[62:0];
    return r;
  endfunction
endpackage

[rtl/sensor_frame_checker.sv]
// Sensor frame checker: one stream byte per item.
// A result appears in the cycle after the byte 27 or end-of-stream item is taken.
// Throughput: one item per cycle; the single result register is the only buffer,
// so input stalls only while a result waits and another result would be due.
// Reset (rst_n, synchronous) clears all frame state and totals and restores
// the threshold registers to -DBL_MAX and +DBL_MAX.
`include "assert_macros.svh"
module sensor_frame_checker import sfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_frame_status,
  output logic        out_alert,
  output logic [15:0] out_sensor_id,
  output logic [31:0] out_sequence_number,
  output logic [31:0] out_value_bits,
  output logic [31:0] out_frame_count,
  output logic [31:0] out_valid_count,
  output logic [31:0] out_corrupt_count,
  output logic [47:0] out_missing_count,
  output logic [31:0] out_regression_count,
  output logic [31:0] out_alert_count,
  output logic        out_trouble,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  logic [63:0] min_r, max_r;
  logic        ovalid_r;
  logic        take, res_due, is_end;
  logic [4:0]  cnt_r;
  frame_t      frame;

  // Byte position mirror: a result is due on an end item or on byte 27.
  assign is_end  = in_opcode == OP_END;
  assign res_due = is_end || cnt_r == FrameLast;
  // Items that produce no result are always taken; a result needs a free register.
  assign in_ready = !ovalid_r || out_ready || !res_due;
  assign take     = in_valid && in_ready;
  assign out_valid = ovalid_r;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n || (take && res_due)) cnt_r <= '0;
    else if (take) cnt_r <= cnt_r + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (take && res_due) ovalid_r <= 1'b1;
    else if (out_ready) ovalid_r <= 1'b0;
  end

  // Configuration registers; each 64-bit register sits at 8*index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MinThrRst;
      max_r <= MaxThrRst;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'd0 && paddr[3:3] == 1'b0) begin
      if (paddr[3] == REG_MIN) min_r <= pwdata;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
      max_r <= pwdata;
    end
  end

  always_comb begin
    case (paddr)
      4'd0:    prdata = min_r;
      4'd8:    prdata = max_r;
      default: prdata = '0;
    endcase
  end

  sfc_parser u_parser (
    .clk, .rst_n, .take, .op_end(is_end), .data_byte(in_data_byte), .frame
  );

  sfc_stats u_stats (
    .clk, .rst_n, .frame, .min_thr(min_r), .max_thr(max_r),
    .frame_status(out_frame_status), .alert(out_alert), .sensor_id(out_sensor_id),
    .sequence_number(out_sequence_number), .value_bits(out_value_bits),
    .frame_count(out_frame_count), .valid_count(out_valid_count),
    .corrupt_count(out_corrupt_count), .missing_count(out_missing_count),
    .regression_count(out_regression_count), .alert_count(out_alert_count),
    .trouble(out_trouble)
  );

  // A result register still waiting must not be overwritten.
  `CHK_IMPLY(a_no_overrun, clk, rst_n, out_valid && !out_ready, !(take && res_due), "result overrun")
  // Every end item clears the byte position.
  `CHK_NEXT(a_end_clears, clk, rst_n, take && is_end, cnt_r == 5'd0, "position not cleared")
  // A result is flagged valid right after an item that causes one.
  `CHK_NEXT(a_result_follows, clk, rst_n, take && res_due, out_valid, "missing result")
endmodule

[rtl/sfc_parser.sv]
// Byte parser: CRC accumulation, header and pad checks, field capture.
// Depends on sfc_pkg.
module sfc_parser import sfc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic       op_end,
  input  logic [7:0] data_byte,
  output frame_t     frame
);
  logic [4:0]  pos_r;
  logic [31:0] crc_r, rcrc_r, seq_r, val_r;
  logic [63:0] ts_r;
  logic [15:0] sen_r;
  logic        hdr_r, pad_r;
  logic [31:0] crc_nxt, rcrc_nxt;
  logic        hdr_nxt, pad_nxt;

  always_comb begin
    crc_nxt  = (pos_r < CrcSpan) ? crc_byte(crc_r, data_byte) : crc_r;
    rcrc_nxt = {rcrc_r[23:0], data_byte};
    hdr_nxt  = hdr_r;
    pad_nxt  = pad_r;
    case (pos_r)
      5'd0: if (data_byte != Magic0) hdr_nxt = 1'b0;
      5'd1: if (data_byte != Magic1) hdr_nxt = 1'b0;
      5'd2: if (data_byte != Version) hdr_nxt = 1'b0;
      5'd3: if (data_byte != FrameLen) hdr_nxt = 1'b0;
      5'd22, 5'd23: if (data_byte != 8'd0) pad_nxt = 1'b0;
      default: ;
    endcase
  end

  always_comb begin
    frame         = '0;
    frame.eos     = take && op_end;
    frame.partial = pos_r != 5'd0;
    frame.fin     = take && !op_end && pos_r == FrameLast;
    frame.hdr_ok  = hdr_nxt;
    frame.crc_ok  = rcrc_nxt == ~crc_r;
    frame.pad_ok  = pad_r;
    frame.seq     = seq_r;
    frame.tstamp  = ts_r;
    frame.sensor  = sen_r;
    frame.value   = val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && (op_end || pos_r == FrameLast))) begin
      pos_r <= '0; crc_r <= Max32; hdr_r <= 1'b1; pad_r <= 1'b1;
      rcrc_r <= '0; seq_r <= '0; ts_r <= '0; sen_r <= '0; val_r <= '0;
    end else if (take) begin
      pos_r <= pos_r + 5'd1;
      crc_r <= crc_nxt;
      hdr_r <= hdr_nxt;
      pad_r <= pad_nxt;
      if (pos_r >= 5'd4 && pos_r <= 5'd7) seq_r <= {seq_r[23:0], data_byte};
      if (pos_r >= 5'd8 && pos_r <= 5'd15) ts_r <= {ts_r[55:0], data_byte};
      if (pos_r == 5'd16 || pos_r == 5'd17) sen_r <= {sen_r[7:0], data_byte};
      if (pos_r >= 5'd18 && pos_r <= 5'd21) val_r <= {val_r[23:0], data_byte};
      if (pos_r >= 5'd24) rcrc_r <= rcrc_nxt;
    end
  end
endmodule

[rtl/sfc_stats.sv]
// Frame accounting: status, sequence tracking, thresholds, saturating totals.
// Depends on sfc_pkg.
module sfc_stats import sfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  frame_t      frame,
  input  logic [63:0] min_thr,
  input  logic [63:0] max_thr,
  output logic [2:0]  frame_status,
  output logic        alert,
  output logic [15:0] sensor_id,
  output logic [31:0] sequence_number,
  output logic [31:0] value_bits,
  output logic [31:0] frame_count,
  output logic [31:0] valid_count,
  output logic [31:0] corrupt_count,
  output logic [47:0] missing_count,
  output logic [31:0] regression_count,
  output logic [31:0] alert_count,
  output logic        trouble
);
  logic [31:0] ftot_r, vtot_r, ctot_r, atot_r, rtot_r, lseq_r;
  logic [47:0] mtot_r;
  logic [63:0] lts_r;
  logic        have_r;
  logic [31:0] ftot_nxt, vtot_nxt, ctot_nxt, atot_nxt, rtot_nxt;
  logic [47:0] mtot_nxt;
  logic [48:0] msum;
  logic [31:0] gap;
  status_t     st;
  logic        al;
  logic [63:0] vd;

  always_comb begin
    ftot_nxt = ftot_r; vtot_nxt = vtot_r; ctot_nxt = ctot_r;
    atot_nxt = atot_r; rtot_nxt = rtot_r; mtot_nxt = mtot_r;
    st = ST_END; al = 1'b0;
    vd = f2d(frame.value);
    gap = frame.seq - lseq_r - 32'd1;
    msum = {1'b0, mtot_r} + {17'd0, gap};
    if (frame.eos) begin
      if (frame.partial) begin
        st = ST_TRUNC; ftot_nxt = inc32(ftot_r); ctot_nxt = inc32(ctot_r);
      end
    end else if (frame.fin) begin
      ftot_nxt = inc32(ftot_r);
      if (!frame.hdr_ok || !frame.crc_ok) begin
        st = ST_BAD_HDR; ctot_nxt = inc32(ctot_r);
      end else if (frame.value[30:23] == 8'hff || !frame.pad_ok) begin
        st = ST_BAD_PAY; ctot_nxt = inc32(ctot_r);
      end else begin
        st = ST_VALID; vtot_nxt = inc32(vtot_r);
        if (have_r) begin
          if (frame.seq <= lseq_r) rtot_nxt = inc32(rtot_r);
          else if (frame.seq > lseq_r + 32'd1)
            mtot_nxt = msum[48] ? Max48 : msum[47:0];
          if (frame.tstamp < lts_r) rtot_nxt = inc32(rtot_nxt);
        end
        al = d_lt(vd, min_thr) || d_lt(max_thr, vd);
        if (al) atot_nxt = inc32(atot_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || frame.eos) begin
      ftot_r <= '0; vtot_r <= '0; ctot_r <= '0; atot_r <= '0;
      rtot_r <= '0; mtot_r <= '0; lseq_r <= '0; lts_r <= '0; have_r <= 1'b0;
    end else if (frame.fin) begin
      ftot_r <= ftot_nxt; vtot_r <= vtot_nxt; ctot_r <= ctot_nxt;
      atot_r <= atot_nxt; rtot_r <= rtot_nxt; mtot_r <= mtot_nxt;
      if (st == ST_VALID) begin
        lseq_r <= frame.seq; lts_r <= frame.tstamp; have_r <= 1'b1;
      end
    end
  end

  // Result payload, captured when a result is produced.
  always_ff @(posedge clk) begin
    if (frame.eos || frame.fin) begin
      frame_status     <= st;
      alert            <= al;
      sensor_id        <= frame.eos ? 16'd0 : frame.sensor;
      sequence_number  <= frame.eos ? 32'd0 : frame.seq;
      value_bits       <= frame.eos ? 32'd0 : frame.value;
      frame_count      <= ftot_nxt;
      valid_count      <= vtot_nxt;
      corrupt_count    <= ctot_nxt;
      missing_count    <= mtot_nxt;
      regression_count <= rtot_nxt;
      alert_count      <= atot_nxt;
      trouble          <= (ctot_nxt != 0) || (mtot_nxt != 0) || (rtot_nxt != 0) ||
                          (atot_nxt != 0);
    end
  end
endmodule

[verif/sfc_checker.sv]
// Scoreboard for the sensor frame checker: keeps its own copy of the frame and
// counter state, predicts each result item and compares it field by field.
// Depends on sfc_pkg for the status codes, opcodes and threshold reset values.
`timescale 1ns / 100ps
module sfc_checker import sfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_frame_status,
  input  logic        out_alert,
  input  logic [15:0] out_sensor_id,
  input  logic [31:0] out_sequence_number,
  input  logic [31:0] out_value_bits,
  input  logic [31:0] out_frame_count,
  input  logic [31:0] out_valid_count,
  input  logic [31:0] out_corrupt_count,
  input  logic [47:0] out_missing_count,
  input  logic [31:0] out_regression_count,
  input  logic [31:0] out_alert_count,
  input  logic        out_trouble,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  output int          fail_count
);
  typedef struct {
    bit [2:0]  status;
    bit        alert;
    bit [15:0] sensor;
    bit [31:0] seq;
    bit [31:0] value;
    bit [31:0] frames;
    bit [31:0] valids;
    bit [31:0] corrupts;
    bit [47:0] missing;
    bit [31:0] regressions;
    bit [31:0] alerts;
    bit        trouble;
  } frame_report_t;

  frame_report_t report_q[$];
  int mismatches;

  bit [63:0] lo_bound, hi_bound;
  bit [4:0]  pos;
  bit [31:0] crc, rx_crc, seq, value, last_seq;
  bit [63:0] tstamp, last_tstamp;
  bit [15:0] sensor;
  bit        hdr_good, pad_good, have_last;
  bit [31:0] n_frames, n_valid, n_corrupt, n_alert, n_regress;
  bit [47:0] n_missing;

  assign fail_count = mismatches + report_q.size();

  function automatic bit [31:0] sat_inc(input bit [31:0] c);
    return (c == 32'hffffffff) ? c : c + 32'd1;
  endfunction

  // Exact value of a finite float32 pattern; scaling by powers of two is exact.
  function automatic real float_value(input bit [31:0] f);
    real mag;
    int  p;
    mag = (f[30:23] == 8'd0) ? real'(f[22:0]) : real'({1'b1, f[22:0]});
    p = (f[30:23] == 8'd0) ? -149 : int'(f[30:23]) - 150;
    while (p > 0) begin
      mag = mag * 2.0;
      p--;
    end
    while (p < 0) begin
      mag = mag * 0.5;
      p++;
    end
    return f[31] ? -mag : mag;
  endfunction

  task automatic clear_frame();
    pos = 0; crc = 32'hffffffff; hdr_good = 1; pad_good = 1;
    rx_crc = 0; seq = 0; tstamp = 0; sensor = 0; value = 0;
  endtask

  task automatic clear_stream();
    clear_frame();
    last_seq = 0; last_tstamp = 0; have_last = 0;
    n_frames = 0; n_valid = 0; n_corrupt = 0; n_alert = 0; n_regress = 0; n_missing = 0;
  endtask

  task automatic push_report(input bit [2:0] st, input bit al, input bit [15:0] sid,
                             input bit [31:0] sq, input bit [31:0] val);
    frame_report_t r;
    r.status = st; r.alert = al; r.sensor = sid; r.seq = sq; r.value = val;
    r.frames = n_frames; r.valids = n_valid; r.corrupts = n_corrupt;
    r.missing = n_missing; r.regressions = n_regress; r.alerts = n_alert;
    r.trouble = (n_corrupt != 0) || (n_missing != 0) || (n_regress != 0) || (n_alert != 0);
    report_q.push_back(r);
  endtask

  task automatic take_item(input logic op, input logic [7:0] b);
    bit [2:0]  st;
    bit        al;
    bit [48:0] sum;
    real       v;
    if (op == OP_END) begin
      st = ST_END;
      if (pos != 0) begin
        n_frames = sat_inc(n_frames);
        n_corrupt = sat_inc(n_corrupt);
        st = ST_TRUNC;
      end
      push_report(st, 0, 0, 0, 0);
      clear_stream();
      return;
    end
    if (pos < CrcSpan) begin
      crc = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) crc = (crc >> 1) ^ (crc[0] ? CrcPoly : 32'd0);
    end
    case (pos)
      0: if (b != Magic0) hdr_good = 0;
      1: if (b != Magic1) hdr_good = 0;
      2: if (b != Version) hdr_good = 0;
      3: if (b != FrameLen) hdr_good = 0;
      4, 5, 6, 7: seq = {seq[23:0], b};
      8, 9, 10, 11, 12, 13, 14, 15: tstamp = {tstamp[55:0], b};
      16, 17: sensor = {sensor[7:0], b};
      18, 19, 20, 21: value = {value[23:0], b};
      22, 23: if (b != 0) pad_good = 0;
      default: rx_crc = {rx_crc[23:0], b};
    endcase
    if (pos != FrameLast) begin
      pos++;
      return;
    end
    al = 0;
    n_frames = sat_inc(n_frames);
    if (!hdr_good || rx_crc != ~crc) begin
      st = ST_BAD_HDR;
      n_corrupt = sat_inc(n_corrupt);
    end else if (value[30:23] == 8'hff || !pad_good) begin
      st = ST_BAD_PAY;
      n_corrupt = sat_inc(n_corrupt);
    end else begin
      st = ST_VALID;
      n_valid = sat_inc(n_valid);
      if (have_last) begin
        if (seq <= last_seq) n_regress = sat_inc(n_regress);
        else if (seq > last_seq + 33'd1) begin
          sum = {1'b0, n_missing} + 49'(seq - last_seq - 32'd1);
          n_missing = sum[48] ? 48'hffffffffffff : sum[47:0];
        end
        if (tstamp < last_tstamp) n_regress = sat_inc(n_regress);
      end
      last_seq = seq;
      last_tstamp = tstamp;
      have_last = 1;
      // Comparisons against a NaN bound come out false, as in IEEE arithmetic.
      v = float_value(value);
      if (v < $bitstoreal(lo_bound) || v > $bitstoreal(hi_bound)) begin
        al = 1;
        n_alert = sat_inc(n_alert);
      end
    end
    push_report(st, al, sensor, seq, value);
    clear_frame();
  endtask

  task automatic check_field(input string name, input bit [63:0] want, input bit [63:0] got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    frame_report_t r;
    if (!rst_n) begin
      lo_bound = MinThrRst;
      hi_bound = MaxThrRst;
      clear_stream();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2:0] == 3'd0) begin
        if (reg_idx_t'(paddr[3]) == REG_MIN) lo_bound = pwdata;
        else hi_bound = pwdata;
      end
      if (in_valid && in_ready) take_item(in_opcode, in_data_byte);
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          $error("result item arrived with no prediction pending");
          mismatches++;
        end else begin
          r = report_q.pop_front();
          check_field("frame_status", r.status, out_frame_status);
          check_field("alert", r.alert, out_alert);
          check_field("sensor_id", r.sensor, out_sensor_id);
          check_field("sequence_number", r.seq, out_sequence_number);
          check_field("value_bits", r.value, out_value_bits);
          check_field("frame_count", r.frames, out_frame_count);
          check_field("valid_count", r.valids, out_valid_count);
          check_field("corrupt_count", r.corrupts, out_corrupt_count);
          check_field("missing_count", r.missing, out_missing_count);
          check_field("regression_count", r.regressions, out_regression_count);
          check_field("alert_count", r.alerts, out_alert_count);
          check_field("trouble", r.trouble, out_trouble);
        end
      end
    end
  end
endmodule

[verif/tb.sv]
// Top of the sensor frame checker testbench: clock, reset, frame stimulus,
// threshold writes and the verdict. Depends on sfc_pkg, sfc_checker and the RTL.
`timescale 1ns / 100ps
module tb;
  import sfc_pkg::*;

  localparam int ItemTarget = 1450;
  localparam int CycleLimit = 400000;
  localparam int LongHold   = 300;

  typedef enum int {FK_GOOD, FK_HEADER, FK_CRC, FK_NONFINITE, FK_PAD, FK_NOISE} frame_kind_t;

  logic        clk, rst_n;
  logic        in_valid, in_ready, in_opcode;
  logic [7:0]  in_data_byte;
  logic        out_valid, out_ready;
  logic [2:0]  out_frame_status;
  logic        out_alert, out_trouble;
  logic [15:0] out_sensor_id;
  logic [31:0] out_sequence_number, out_value_bits, out_frame_count, out_valid_count;
  logic [31:0] out_corrupt_count, out_regression_count, out_alert_count;
  logic [47:0] out_missing_count;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [63:0] pwdata, prdata;

  int fail_count;
  int items_sent, results_due, results_seen, cycles;
  int hold_requests;   // bumped by the stimulus to ask for one long receiver stall
  bit no_idle;         // both sides run flat out while set
  bit [4:0]  stream_pos;
  bit [31:0] next_seq;
  bit [63:0] next_tstamp;

  sensor_frame_checker dut (.*);

  sfc_checker scoreboard (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // A run that hangs is a failure; the limit is far above the slowest legal run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready) results_seen++;

  // Receiver: a random wait after each result item (none while no_idle is set), plus
  // a single long hold-off on request so the result register backs up into the input.
  initial begin
    int wait_left, hold_left, holds_taken;
    wait_left = 0;
    hold_left = 0;
    holds_taken = 0;
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_taken) begin
        holds_taken = hold_requests;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 0;
      end else if (wait_left > 0) begin
        wait_left--;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
        if (out_valid && out_ready) wait_left = no_idle ? 0 : $urandom_range(0, 3);
      end
    end
  end

  function automatic bit [31:0] frame_crc(input bit [7:0] bytes [28]);
    bit [31:0] c;
    c = 32'hffffffff;
    for (int i = 0; i < 24; i++) begin
      c = c ^ {24'd0, bytes[i]};
      for (int k = 0; k < 8; k++) c = (c >> 1) ^ (c[0] ? 32'hedb88320 : 32'd0);
    end
    return ~c;
  endfunction

  // One item on the input channel. Valid stays up between items when no gap is drawn.
  task automatic send_item(input opcode_t op, input bit [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_opcode <= op;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (op == OP_END) begin
      results_due++;
      stream_pos = 0;
    end else if (stream_pos == 27) begin
      results_due++;
      stream_pos = 0;
    end else begin
      stream_pos++;
    end
  endtask

  // Waits out every pending result, then lets the block settle.
  task automatic drain();
    if (in_valid) in_valid <= 0;
    while (results_seen != results_due) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input bit [63:0] data);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= {idx, 3'b000};
    pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(posedge clk);
  endtask

  // Float values: ordinary ones near the alert bounds, zeros, subnormals,
  // the largest finite magnitudes, and unrestricted bit patterns.
  function automatic bit [31:0] pick_value();
    bit [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v = {v[31], 31'd0};
      1: v = {v[31], 8'd0, v[22:0]};
      2: v = {v[31], 8'hfe, v[22:0]};
      3, 4, 5: v = {v[31], 8'($urandom_range(120, 133)), v[22:0]};
      default: ;
    endcase
    return v;
  endfunction

  // Sends one 28-byte frame, or its first keep bytes when keep is below 28.
  task automatic send_frame(input frame_kind_t kind, input bit [31:0] sq,
                            input bit [63:0] ts, input bit [31:0] val, input int keep);
    bit [7:0]  bytes [28];
    bit [31:0] c;
    bit [15:0] sid;
    int        idx;
    sid = 16'($urandom);
    bytes[0] = Magic0; bytes[1] = Magic1; bytes[2] = Version; bytes[3] = FrameLen;
    for (int i = 0; i < 4; i++) bytes[4 + i] = sq[31 - 8*i -: 8];
    for (int i = 0; i < 8; i++) bytes[8 + i] = ts[63 - 8*i -: 8];
    bytes[16] = sid[15:8]; bytes[17] = sid[7:0];
    for (int i = 0; i < 4; i++) bytes[18 + i] = val[31 - 8*i -: 8];
    bytes[22] = 0; bytes[23] = 0;
    if (kind == FK_NONFINITE) bytes[18][6:0] = 7'h7f;
    if (kind == FK_NONFINITE) bytes[19][7] = 1'b1;
    if (kind == FK_PAD) bytes[22 + $urandom_range(0, 1)] = 8'($urandom_range(1, 255));
    if (kind == FK_HEADER) begin
      idx = $urandom_range(0, 3);
      bytes[idx] = bytes[idx] ^ 8'($urandom_range(1, 255));
    end
    c = frame_crc(bytes);
    for (int i = 0; i < 4; i++) bytes[24 + i] = c[31 - 8*i -: 8];
    // A CRC failure is either a damaged check word or a damaged covered byte.
    if (kind == FK_CRC) bytes[$urandom_range(0, 27)] ^= 8'(1 << $urandom_range(0, 7));
    if (kind == FK_NOISE) foreach (bytes[i]) bytes[i] = 8'($urandom);
    for (int i = 0; i < keep; i++) send_item(OP_DATA, bytes[i]);
  endtask

  // A frame with random content; the sequence mostly counts up by one, with
  // occasional gaps, repeats and steps back, and the timestamp mostly rises.
  task automatic send_random_frame();
    frame_kind_t kind;
    int r;
    r = $urandom_range(0, 99);
    kind = r < 70 ? FK_GOOD : r < 76 ? FK_HEADER : r < 84 ? FK_CRC :
           r < 90 ? FK_NONFINITE : r < 95 ? FK_PAD : FK_NOISE;
    r = $urandom_range(0, 19);
    if (r < 14) next_seq = next_seq + 1;
    else if (r < 16) next_seq = next_seq + $urandom_range(2, 9);
    else if (r == 16) next_seq = next_seq + $urandom;
    else if (r == 17) ;
    else next_seq = next_seq - $urandom_range(1, 5);
    if ($urandom_range(0, 9) == 0) next_tstamp = next_tstamp - $urandom_range(1, 1000);
    else next_tstamp = next_tstamp + $urandom_range(0, 5000);
    send_frame(kind, next_seq, next_tstamp, pick_value(), 28);
  endtask

  // Random traffic until the item count reaches the mark, then a clean end of stream.
  task automatic run_phase(input int upto);
    next_seq = $urandom;
    next_tstamp = {$urandom, $urandom};
    while (items_sent < upto) begin
      case ($urandom_range(0, 29))
        0: send_frame(FK_GOOD, next_seq, next_tstamp, pick_value(), $urandom_range(1, 27));
        1: send_item(OP_END, 8'($urandom));
        default: send_random_frame();
      endcase
      if (stream_pos != 0) send_item(OP_END, 8'($urandom));
    end
    send_item(OP_END, 8'($urandom));
    drain();
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_opcode = OP_DATA;
    in_data_byte = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    no_idle = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: end of an empty stream, a clean first frame, the sequence
    // wrapping to zero, the extremes of sequence and timestamp, each kind of
    // corruption, and a partial frame closed by end of stream.
    send_item(OP_END, 8'hff);
    send_frame(FK_GOOD, 32'hffffffff, 64'hffffffffffffffff, 32'h7f7fffff, 28);
    send_frame(FK_GOOD, 32'h0, 64'h0, 32'h80000001, 28);
    send_frame(FK_GOOD, 32'h0, 64'h1, 32'h00000000, 28);
    send_frame(FK_GOOD, 32'h3, 64'h2, 32'hff7fffff, 28);
    send_frame(FK_HEADER, 32'h4, 64'h3, 32'h3f800000, 28);
    send_frame(FK_CRC, 32'h5, 64'h4, 32'h3f800000, 28);
    send_frame(FK_NONFINITE, 32'h6, 64'h5, 32'h3f800000, 28);
    send_frame(FK_PAD, 32'h7, 64'h6, 32'h3f800000, 28);
    send_frame(FK_GOOD, 32'h8, 64'h7, 32'h3f800000, 27);
    send_item(OP_END, 8'h00);
    drain();

    // Random traffic under default bounds, then a long receiver stall while
    // frames keep coming, so the result register fills and stalls the input.
    run_phase(350);
    hold_requests++;
    run_phase(500);

    // Bounds of -1.0 and +1.0.
    write_reg(REG_MIN, 64'hbff0000000000000);
    write_reg(REG_MAX, 64'h3ff0000000000000);
    run_phase(750);

    // Both bounds at zero, with no idling on either side.
    write_reg(REG_MIN, 64'h0);
    write_reg(REG_MAX, 64'h0);
    no_idle = 1;
    run_phase(950);
    no_idle = 0;

    // Bounds out of order.
    write_reg(REG_MIN, 64'h3ff0000000000000);
    write_reg(REG_MAX, 64'hbff0000000000000);
    run_phase(1150);

    // A NaN bound on each side; every comparison with it is false.
    write_reg(REG_MIN, 64'hffffffffffffffff);
    write_reg(REG_MAX, 64'h7ff8000000000001);
    run_phase(1300);

    // Back to the widest finite bounds.
    write_reg(REG_MIN, 64'hffefffffffffffff);
    write_reg(REG_MAX, 64'h7fefffffffffffff);
    run_phase(ItemTarget);

    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl
rtl/sfc_pkg.sv
rtl/sfc_parser.sv
rtl/sfc_stats.sv
rtl/sensor_frame_checker.sv
verif/sfc_checker.sv
verif/tb.sv
